// File: hdl/pwo_pkg.sv
// Package for the polyline width offset unit.
// Holds the fixed widths, the sequencer state type and the normalization phase type.
// No dependencies.
`default_nettype none
package pwo_pkg;

	localparam int COORD_BITS = 32;
	localparam int WIDTH_BITS = 22;
	localparam int UNIT_FRAC  = 30;
	localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 22'd65536;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MAG,
		S_SQ,
		S_SQRT,
		S_DIV,
		S_NEXT,
		S_EH,
		S_EP,
		S_OFSX,
		S_OFSY,
		S_SUM,
		S_OUT,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		PH_A,
		PH_B,
		PH_T
	} phase_t;

endpackage
`default_nettype wire

// File: hdl/polyline_width_offset_unit.sv
// Top level of the polyline width offset unit: border points from polyline vertices.
// One shared normalize unit (square sum, bit-pair square root, restoring divide).
// Depends on pwo_pkg.
//
// channel | dir | handshake              | payload
// s       | in  | s_tvalid/s_tready      | s_tdata x,y,z; s_tlast final_vertex
// m       | out | m_tvalid/m_tready      | m_tdata left/right x,y, z; m_tlast; m_tuser
// cfg     | in  | stroke_width_we        | stroke_width
//
// A first vertex is only stored. Every other vertex needs one normalization (second vertex
// of a line) or three (inner vertex), each a square sum, the shared 31-step square root
// and three 31-step divides; each result then passes the offset, sum and output states.
// s_tready is high only while idle; the block waits on m_tready with the result held.
// Reset clears the point count and loads a stroke width of 1.0.
`default_nettype none
module polyline_width_offset_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [95:0]   s_tdata,  // point_x, point_y, point_z
	input  wire logic          s_tlast,  // final_vertex
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [159:0]       m_tdata,  // left_x, left_y, right_x, right_y, border_z
	output logic               m_tlast,  // run_last
	output logic               m_tuser,  // line_done
	input  wire logic          stroke_width_we,
	input  wire logic [21:0]   stroke_width
);

	pwo_pkg::state_t state_q, state_d;
	pwo_pkg::phase_t phase_q;

	logic [1:0]         cnt_q;
	logic [21:0]        width_q;
	logic signed [31:0] held_q [3];
	logic signed [31:0] before_q [3];
	logic signed [31:0] pin_q [3];
	logic               fin_q;
	logic signed [32:0] vec_q [3];
	logic [29:0]        m_q [3];
	logic               neg_q [3];
	logic [61:0]        sum_q;
	logic [1:0]         idx_q;
	logic [61:0]        x_q;
	logic [61:0]        r_q;
	logic [61:0]        bit_q;
	logic [30:0]        n_q;
	logic [31:0]        rem_q;
	logic [30:0]        q_q;
	logic [4:0]         dcnt_q;
	logic signed [31:0] u_q [3];
	logic signed [31:0] ua_q [3];
	logic               nz_q;
	logic               anz_q;
	logic signed [31:0] eu_q [2];
	logic signed [31:0] ep_q [3];
	logic               done_q;
	logic               last_q;
	logic               emitp_q;
	logic signed [22:0] ox_q;
	logic signed [22:0] oy_q;
	logic [159:0]       data_q;

	logic               acc;
	logic [32:0]        mg [3];
	logic [32:0]        mor;
	logic [1:0]         sh;
	logic [59:0]        sq;
	logic [61:0]        sum_nx;
	logic [61:0]        rb;
	logic               sge;
	logic [61:0]        r_nx;
	logic [31:0]        tr;
	logic               dge;
	logic [30:0]        qn;
	logic signed [31:0] unit;
	logic signed [31:0] comp;
	logic [30:0]        umag;
	logic [52:0]        prod;
	logic [52:0]        rnd;
	logic [21:0]        pr;
	logic signed [22:0] prs;

	function automatic logic [31:0] sat(input logic signed [32:0] v);
		if (v[32] != v[31]) begin
			return v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
		end
		return v[31:0];
	endfunction

	assign acc      = s_tvalid && s_tready;
	assign s_tready = (state_q == pwo_pkg::S_IDLE);
	assign m_tvalid = (state_q == pwo_pkg::S_OUT);
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;
	assign m_tuser  = done_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mg[i] = vec_q[i][32] ? 33'(-vec_q[i]) : 33'(vec_q[i]);
		end
		mor = mg[0] | mg[1] | mg[2];
		if (mor[32]) begin
			sh = 2'd3;
		end else if (mor[31]) begin
			sh = 2'd2;
		end else if (mor[30]) begin
			sh = 2'd1;
		end else begin
			sh = 2'd0;
		end
		sq     = m_q[idx_q] * m_q[idx_q];
		sum_nx = sum_q + 62'(sq);
		rb     = r_q + bit_q;
		sge    = (x_q >= rb);
		r_nx   = sge ? ((r_q >> 1) + bit_q) : (r_q >> 1);
		tr     = (dcnt_q == 5'd0) ? rem_q : {rem_q[30:0], 1'b0};
		dge    = (tr >= {1'b0, n_q});
		qn     = {q_q[29:0], dge};
		unit   = neg_q[idx_q] ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
		comp   = (state_q == pwo_pkg::S_OFSX) ? eu_q[1] : eu_q[0];
		umag   = comp[31] ? 31'(-comp) : 31'(comp);
		prod   = width_q * umag;
		rnd    = prod + (53'd1 << pwo_pkg::UNIT_FRAC);
		pr     = rnd[52:31];
		prs    = $signed({1'b0, pr});
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pwo_pkg::S_IDLE: begin
				if (acc && cnt_q != 2'd0) begin
					state_d = pwo_pkg::S_MAG;
				end
			end
			pwo_pkg::S_MAG:  state_d = (mor == 33'd0) ? pwo_pkg::S_NEXT : pwo_pkg::S_SQ;
			pwo_pkg::S_SQ:   state_d = (idx_q == 2'd2) ? pwo_pkg::S_SQRT : pwo_pkg::S_SQ;
			pwo_pkg::S_SQRT: state_d = bit_q[0] ? pwo_pkg::S_DIV : pwo_pkg::S_SQRT;
			pwo_pkg::S_DIV: begin
				if (dcnt_q == 5'd30 && idx_q == 2'd2) begin
					state_d = pwo_pkg::S_NEXT;
				end
			end
			pwo_pkg::S_NEXT: begin
				unique case (phase_q)
					pwo_pkg::PH_A: state_d = (cnt_q == 2'd1) ? pwo_pkg::S_EH : pwo_pkg::S_MAG;
					pwo_pkg::PH_B: state_d = pwo_pkg::S_MAG;
					pwo_pkg::PH_T: state_d = pwo_pkg::S_EH;
					default:       state_d = pwo_pkg::S_EH;
				endcase
			end
			pwo_pkg::S_EH:   state_d = nz_q ? pwo_pkg::S_OFSX : pwo_pkg::S_EP;
			pwo_pkg::S_EP:   state_d = (fin_q && anz_q) ? pwo_pkg::S_OFSX : pwo_pkg::S_FIN;
			pwo_pkg::S_OFSX: state_d = pwo_pkg::S_OFSY;
			pwo_pkg::S_OFSY: state_d = pwo_pkg::S_SUM;
			pwo_pkg::S_SUM:  state_d = pwo_pkg::S_OUT;
			pwo_pkg::S_OUT: begin
				if (m_tready) begin
					state_d = emitp_q ? pwo_pkg::S_FIN : pwo_pkg::S_EP;
				end
			end
			pwo_pkg::S_FIN:  state_d = pwo_pkg::S_IDLE;
			default:         state_d = pwo_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pwo_pkg::S_IDLE;
			phase_q <= pwo_pkg::PH_A;
			cnt_q   <= 2'd0;
			width_q <= pwo_pkg::WIDTH_RESET;
		end else begin
			state_q <= state_d;
			if (stroke_width_we) begin
				width_q <= stroke_width;
			end
			if (state_q == pwo_pkg::S_IDLE && acc) begin
				phase_q <= pwo_pkg::PH_A;
				if (cnt_q == 2'd0 && !s_tlast) begin
					cnt_q <= 2'd1;
				end
			end
			if (state_q == pwo_pkg::S_NEXT) begin
				if (phase_q == pwo_pkg::PH_A) begin
					phase_q <= pwo_pkg::PH_B;
				end else if (phase_q == pwo_pkg::PH_B) begin
					phase_q <= pwo_pkg::PH_T;
				end
			end
			if (state_q == pwo_pkg::S_FIN) begin
				cnt_q <= fin_q ? 2'd0 : 2'd2;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pwo_pkg::S_IDLE: begin
				if (acc) begin
					for (int i = 0; i < 3; i++) begin
						pin_q[i] <= $signed(s_tdata[32*i +: 32]);
						vec_q[i] <= $signed({s_tdata[32*i+31], s_tdata[32*i +: 32]})
							- $signed({held_q[i][31], held_q[i]});
						if (cnt_q == 2'd0) begin
							held_q[i] <= $signed(s_tdata[32*i +: 32]);
						end
					end
					fin_q <= s_tlast;
				end
			end
			pwo_pkg::S_MAG: begin
				nz_q  <= (mor != 33'd0);
				sum_q <= 62'd0;
				idx_q <= 2'd0;
				for (int i = 0; i < 3; i++) begin
					m_q[i]   <= 30'(mg[i] >> sh);
					neg_q[i] <= vec_q[i][32];
					if (mor == 33'd0) begin
						u_q[i] <= 32'sd0;
					end
				end
			end
			pwo_pkg::S_SQ: begin
				sum_q <= sum_nx;
				idx_q <= idx_q + 2'd1;
				if (idx_q == 2'd2) begin
					x_q   <= sum_nx;
					r_q   <= 62'd0;
					bit_q <= 62'd1 << 60;
				end
			end
			pwo_pkg::S_SQRT: begin
				if (sge) begin
					x_q <= x_q - rb;
				end
				r_q   <= r_nx;
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					n_q    <= r_nx[30:0];
					idx_q  <= 2'd0;
					rem_q  <= {2'b0, m_q[0]};
					q_q    <= 31'd0;
					dcnt_q <= 5'd0;
				end
			end
			pwo_pkg::S_DIV: begin
				if (dcnt_q == 5'd30) begin
					u_q[idx_q] <= unit;
					idx_q      <= idx_q + 2'd1;
					rem_q      <= {2'b0, m_q[idx_q + 2'd1]};
					q_q        <= 31'd0;
					dcnt_q     <= 5'd0;
				end else begin
					rem_q  <= dge ? (tr - {1'b0, n_q}) : tr;
					q_q    <= qn;
					dcnt_q <= dcnt_q + 5'd1;
				end
			end
			pwo_pkg::S_NEXT: begin
				unique case (phase_q)
					pwo_pkg::PH_A: begin
						ua_q  <= u_q;
						anz_q <= nz_q;
						for (int i = 0; i < 3; i++) begin
							vec_q[i] <= $signed({held_q[i][31], held_q[i]})
								- $signed({before_q[i][31], before_q[i]});
						end
					end
					pwo_pkg::PH_B: begin
						for (int i = 0; i < 3; i++) begin
							vec_q[i] <= 33'(ua_q[i]) + 33'(u_q[i]);
						end
					end
					pwo_pkg::PH_T: ;
					default: ;
				endcase
			end
			pwo_pkg::S_EH: begin
				eu_q[0] <= u_q[0];
				eu_q[1] <= u_q[1];
				ep_q    <= held_q;
				done_q  <= 1'b0;
				last_q  <= !(fin_q && anz_q);
				emitp_q <= 1'b0;
			end
			pwo_pkg::S_EP: begin
				eu_q[0] <= ua_q[0];
				eu_q[1] <= ua_q[1];
				ep_q    <= pin_q;
				done_q  <= 1'b1;
				last_q  <= 1'b1;
				emitp_q <= 1'b1;
			end
			pwo_pkg::S_OFSX: ox_q <= comp[31] ? prs : -prs;
			pwo_pkg::S_OFSY: oy_q <= comp[31] ? -prs : prs;
			pwo_pkg::S_SUM: begin
				data_q[31:0]    <= sat(33'(ep_q[0]) + 33'(ox_q));
				data_q[63:32]   <= sat(33'(ep_q[1]) + 33'(oy_q));
				data_q[95:64]   <= sat(33'(ep_q[0]) - 33'(ox_q));
				data_q[127:96]  <= sat(33'(ep_q[1]) - 33'(oy_q));
				data_q[159:128] <= ep_q[2];
			end
			pwo_pkg::S_FIN: begin
				if (!fin_q) begin
					before_q <= held_q;
					held_q   <= pin_q;
				end
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken while result pending");
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast) else $error("final vertex result not last");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pwo_pkg::S_DIV) |-> (n_q != 31'd0)) else $error("zero divisor");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("bad point count");
`endif

endmodule
`default_nettype wire
